// File: sv/flash_command_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Flash command sequencer assertion macros
// Short forms for the concurrent checks used on the sequencer's ports.
// ----------------------------------------------------------------------------
`ifndef FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define FLASH_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// A property that is checked on every clock edge outside reset.
`define FCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("flash command sequencer check failed");

// A property that is checked on every clock edge, reset included.
`define FCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("flash command sequencer check failed");

`endif

// File: sv/fcs_pkg.sv
// ----------------------------------------------------------------------------
// Flash command sequencer package
// Shared field widths, codes and item types of the flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

   // Field widths of the channels and the register port.
   localparam int TIMEOUT_W = 24;
   localparam int CODE_W    = 4;
   localparam int ACTION_W  = 3;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Event codes of an input item.
   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_DONE    = 2'd1,
      OP_TICK    = 2'd2,
      OP_REFUSED = 2'd3
   } fcs_op_type;

   // Actions of a result item.
   localparam logic [ACTION_W-1:0] ACT_WREN     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CMD      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PAYLOAD  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POLL     = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ABORT    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_COMPLETE = 3'd5;

   // Completion status codes.
   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REFUSED       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_XFER_ERR      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABORT_TIMEOUT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABORTED       = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABORT_TIMEOUT   = 2'd2;

   // Register reset values.
   localparam logic [TIMEOUT_W-1:0] COMMAND_TIMEOUT_RESET = 24'd1000;
   localparam logic [TIMEOUT_W-1:0] PAYLOAD_TIMEOUT_RESET = 24'd10000;
   localparam logic [TIMEOUT_W-1:0] ABORT_TIMEOUT_RESET   = 24'd1000;

   // A classified input item as it waits in the queue.
   typedef struct packed {
      fcs_op_type           op;
      logic                 wren_needed;
      logic                 has_payload;
      logic                 poll_needed;
      logic [TIMEOUT_W-1:0] poll_delay;
      logic [TIMEOUT_W-1:0] poll_timeout;
      logic                 code_ok;
      logic [CODE_W-1:0]    done_code;
   } fcs_item_type;

   // One result item.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [STATUS_W-1:0] status;
      logic [CODE_W-1:0]   error_detail;
      logic                last;
   } fcs_result_type;

endpackage

`default_nettype wire

// File: sv/fcs_req_if.sv
// ----------------------------------------------------------------------------
// Flash command sequencer request channel
// Valid and ready handshake carrying one event item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcs_req_if import fcs_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [1:0]           opcode;
   logic                 wren_needed;
   logic                 has_payload;
   logic                 poll_needed;
   logic [TIMEOUT_W-1:0] poll_delay;
   logic [TIMEOUT_W-1:0] poll_timeout;
   logic [CODE_W-1:0]    done_code;

   modport source (
      output valid, opcode, wren_needed, has_payload, poll_needed,
             poll_delay, poll_timeout, done_code,
      input  ready
   );

   modport sink (
      input  valid, opcode, wren_needed, has_payload, poll_needed,
             poll_delay, poll_timeout, done_code,
      output ready
   );

endinterface

`default_nettype wire

// File: sv/fcs_rsp_if.sv
// ----------------------------------------------------------------------------
// Flash command sequencer response channel
// Valid and ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcs_rsp_if import fcs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [STATUS_W-1:0] status;
   logic [CODE_W-1:0]   error_detail;
   logic                last;

   modport source (
      output valid, action, status, error_detail, last,
      input  ready
   );

   modport sink (
      input  valid, action, status, error_detail, last,
      output ready
   );

endinterface

`default_nettype wire

// File: sv/fcs_front.sv
// ----------------------------------------------------------------------------
// Flash command sequencer front end
// Accepts event items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_front import fcs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   fcs_req_if.sink           req_port,
   output fcs_item_type      q_item,
   output logic              q_valid,
   input  wire logic         q_pop
);

   fcs_item_type entries_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   fcs_item_type classified;

   // Decode the raw event into the form the back end works on.
   always_comb begin
      classified.op           = fcs_op_type'(req_port.opcode);
      classified.wren_needed  = req_port.wren_needed;
      classified.has_payload  = req_port.has_payload;
      classified.poll_needed  = req_port.poll_needed;
      classified.poll_delay   = req_port.poll_delay;
      classified.poll_timeout = req_port.poll_timeout;
      classified.code_ok      = (req_port.done_code == '0);
      classified.done_code    = req_port.done_code;
   end

   // The queue takes an item whenever it has a free entry.
   assign req_port.ready = (count_ff != 2'd2);
   assign push           = req_port.valid && req_port.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_item         = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// File: sv/fcs_engine.sv
// ----------------------------------------------------------------------------
// Flash command sequencer back end
// Runs the command phases, tick timeouts and aborts, and emits result items.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_engine import fcs_pkg::*; #(
   parameter int TICK_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fcs_item_type         q_item,
   input  wire logic                 q_valid,
   output logic                      q_pop,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIMEOUT_W-1:0] csr_data,
   output logic                      rsp_valid,
   output fcs_result_type            rsp_result,
   input  wire logic                 rsp_ready
);

   localparam int CMP_BITS = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WREN_WAIT,
      PH_CMD_WAIT,
      PH_PAYLOAD_WAIT,
      PH_POLL_DELAY,
      PH_POLL_WAIT,
      PH_ABORT_WAIT
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [TICK_BITS-1:0] elapsed_ff, elapsed_in;
   logic                 pend_payload_ff, pend_payload_in;
   logic                 pend_poll_ff, pend_poll_in;
   logic [TIMEOUT_W-1:0] poll_delay_ff, poll_delay_in;
   logic [TIMEOUT_W-1:0] poll_timeout_ff, poll_timeout_in;
   logic [TIMEOUT_W-1:0] cmd_timeout_ff, cmd_timeout_in;
   logic [TIMEOUT_W-1:0] pay_timeout_ff, pay_timeout_in;
   logic [TIMEOUT_W-1:0] abort_timeout_ff, abort_timeout_in;
   fcs_result_type       slot0_ff, slot0_in;
   fcs_result_type       slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;

   logic [TICK_BITS-1:0] elapsed_step;
   logic [TIMEOUT_W-1:0] limit;
   logic                 expired;
   fcs_result_type       res0, res1;
   logic [1:0]           n_res;

   function automatic fcs_result_type make_result(
      input logic [ACTION_W-1:0] action,
      input logic [STATUS_W-1:0] status,
      input logic [CODE_W-1:0]   detail
   );
      fcs_result_type r;
      r.action       = action;
      r.status       = status;
      r.error_detail = detail;
      r.last         = 1'b0;
      return r;
   endfunction

   // Take the next item once the result buffer is empty or is emptying now.
   assign q_pop = q_valid &&
                  ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready));

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_result = slot0_ff;

   // Saturating tick count and the limit of the current wait.
   always_comb begin
      elapsed_step = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_BITS'(1);
      case (phase_ff)
         PH_WREN_WAIT, PH_CMD_WAIT: limit = cmd_timeout_ff;
         PH_PAYLOAD_WAIT:           limit = pay_timeout_ff;
         PH_POLL_DELAY:             limit = poll_delay_ff;
         PH_POLL_WAIT:              limit = poll_timeout_ff;
         PH_ABORT_WAIT:             limit = abort_timeout_ff;
         default:                   limit = '0;
      endcase
      expired = (CMP_BITS'(elapsed_step) >= CMP_BITS'(limit));
   end

   // Configuration register writes.
   always_comb begin
      cmd_timeout_in   = cmd_timeout_ff;
      pay_timeout_in   = pay_timeout_ff;
      abort_timeout_in = abort_timeout_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COMMAND_TIMEOUT: cmd_timeout_in   = csr_data;
            CSR_PAYLOAD_TIMEOUT: pay_timeout_in   = csr_data;
            CSR_ABORT_TIMEOUT:   abort_timeout_in = csr_data;
            default:             ;
         endcase
      end
   end

   // Phase sequencing of one popped item; up to two results come of it.
   always_comb begin
      phase_in        = phase_ff;
      elapsed_in      = elapsed_ff;
      pend_payload_in = pend_payload_ff;
      pend_poll_in    = pend_poll_ff;
      poll_delay_in   = poll_delay_ff;
      poll_timeout_in = poll_timeout_ff;
      res0            = make_result(ACT_COMPLETE, ST_OK, '0);
      res1            = make_result(ACT_COMPLETE, ST_OK, '0);
      n_res           = 2'd0;

      if (q_pop) begin
         unique case (q_item.op)
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  pend_payload_in = q_item.has_payload;
                  pend_poll_in    = q_item.poll_needed;
                  poll_delay_in   = q_item.poll_delay;
                  poll_timeout_in = q_item.poll_timeout;
                  elapsed_in      = '0;
                  n_res           = 2'd1;
                  if (q_item.wren_needed) begin
                     res0     = make_result(ACT_WREN, ST_OK, '0);
                     phase_in = PH_WREN_WAIT;
                  end else if (q_item.has_payload) begin
                     res0     = make_result(ACT_CMD, ST_OK, '0);
                     res1     = make_result(ACT_PAYLOAD, ST_OK, '0);
                     n_res    = 2'd2;
                     phase_in = PH_PAYLOAD_WAIT;
                  end else begin
                     res0     = make_result(ACT_CMD, ST_OK, '0);
                     phase_in = PH_CMD_WAIT;
                  end
               end
            end
            OP_DONE: begin
               case (phase_ff)
                  PH_WREN_WAIT: begin
                     elapsed_in = '0;
                     n_res      = 2'd1;
                     if (!q_item.code_ok) begin
                        res0     = make_result(ACT_COMPLETE, ST_XFER_ERR, q_item.done_code);
                        phase_in = PH_IDLE;
                     end else if (pend_payload_ff) begin
                        res0     = make_result(ACT_CMD, ST_OK, '0);
                        res1     = make_result(ACT_PAYLOAD, ST_OK, '0);
                        n_res    = 2'd2;
                        phase_in = PH_PAYLOAD_WAIT;
                     end else begin
                        res0     = make_result(ACT_CMD, ST_OK, '0);
                        phase_in = PH_CMD_WAIT;
                     end
                  end
                  PH_CMD_WAIT, PH_PAYLOAD_WAIT: begin
                     elapsed_in = '0;
                     if (!q_item.code_ok) begin
                        res0     = make_result(ACT_COMPLETE, ST_XFER_ERR, q_item.done_code);
                        n_res    = 2'd1;
                        phase_in = PH_IDLE;
                     end else if (!pend_poll_ff) begin
                        res0     = make_result(ACT_COMPLETE, ST_OK, '0);
                        n_res    = 2'd1;
                        phase_in = PH_IDLE;
                     end else if (poll_delay_ff != '0) begin
                        phase_in = PH_POLL_DELAY;
                     end else begin
                        res0     = make_result(ACT_POLL, ST_OK, '0);
                        n_res    = 2'd1;
                        phase_in = PH_POLL_WAIT;
                     end
                  end
                  PH_POLL_WAIT: begin
                     res0       = make_result(ACT_COMPLETE,
                                              q_item.code_ok ? ST_OK : ST_XFER_ERR,
                                              q_item.done_code);
                     n_res      = 2'd1;
                     phase_in   = PH_IDLE;
                     elapsed_in = '0;
                  end
                  PH_ABORT_WAIT: begin
                     res0       = q_item.code_ok ?
                                  make_result(ACT_COMPLETE, ST_ABORTED, '0) :
                                  make_result(ACT_COMPLETE, ST_XFER_ERR, q_item.done_code);
                     n_res      = 2'd1;
                     phase_in   = PH_IDLE;
                     elapsed_in = '0;
                  end
                  default: ;
               endcase
            end
            OP_TICK: begin
               // Idle does not count ticks; every wait phase does.
               if (phase_ff != PH_IDLE) begin
                  elapsed_in = elapsed_step;
                  if (expired) begin
                     elapsed_in = '0;
                     n_res      = 2'd1;
                     case (phase_ff)
                        PH_POLL_DELAY: begin
                           res0     = make_result(ACT_POLL, ST_OK, '0);
                           phase_in = PH_POLL_WAIT;
                        end
                        PH_ABORT_WAIT: begin
                           res0     = make_result(ACT_COMPLETE, ST_ABORT_TIMEOUT, '0);
                           phase_in = PH_IDLE;
                        end
                        default: begin
                           res0     = make_result(ACT_ABORT, ST_OK, '0);
                           phase_in = PH_ABORT_WAIT;
                        end
                     endcase
                  end
               end
            end
            OP_REFUSED: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_POLL_DELAY) begin
                  res0       = make_result(ACT_COMPLETE, ST_REFUSED, '0);
                  n_res      = 2'd1;
                  phase_in   = PH_IDLE;
                  elapsed_in = '0;
               end
            end
         endcase
      end

      // Mark the final result that this item caused.
      if (n_res == 2'd1) begin
         res0.last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   // Result buffer: the head slot drives the channel, the second slot waits.
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (q_pop) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = n_res;
      end else if (rsp_ready && count_ff == 2'd2) begin
         slot0_in = slot1_ff;
         count_in = 2'd1;
      end else if (rsp_ready && count_ff == 2'd1) begin
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         elapsed_ff       <= '0;
         pend_payload_ff  <= 1'b0;
         pend_poll_ff     <= 1'b0;
         poll_delay_ff    <= '0;
         poll_timeout_ff  <= '0;
         cmd_timeout_ff   <= COMMAND_TIMEOUT_RESET;
         pay_timeout_ff   <= PAYLOAD_TIMEOUT_RESET;
         abort_timeout_ff <= ABORT_TIMEOUT_RESET;
         count_ff         <= 2'd0;
      end else begin
         phase_ff         <= phase_in;
         elapsed_ff       <= elapsed_in;
         pend_payload_ff  <= pend_payload_in;
         pend_poll_ff     <= pend_poll_in;
         poll_delay_ff    <= poll_delay_in;
         poll_timeout_ff  <= poll_timeout_in;
         cmd_timeout_ff   <= cmd_timeout_in;
         pay_timeout_ff   <= pay_timeout_in;
         abort_timeout_ff <= abort_timeout_in;
         count_ff         <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// File: sv/flash_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Flash command sequencer
// Sequences one flash command with timeouts, aborts and a final completion.
// ----------------------------------------------------------------------------
// Each event item enters a two-entry queue and is registered there before the
// sequencing engine takes it; the engine registers its results in a two-slot
// result buffer, whose head slot is offered on the response channel. The
// engine takes one item per cycle while its result buffer is empty or
// emptying; an item that causes two results fills both slots, so the next
// item waits until the second result is being taken. Configuration registers
// are written through the plain write port; a wait reads its limit from them
// at every tick item, so a write also affects a wait already under way.
`default_nettype none

module flash_command_sequencer_unit import fcs_pkg::*; #(
   parameter int TICK_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fcs_req_if.sink                   req_port,
   fcs_rsp_if.source                 rsp_port,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIMEOUT_W-1:0] csr_data
);

   fcs_item_type   q_item;
   logic           q_valid;
   logic           q_pop;
   logic           rsp_valid;
   fcs_result_type rsp_result;

   // Front end: accept and classify items.
   fcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   // Back end: run the command phases.
   fcs_engine #(
      .TICK_BITS (TICK_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_ready  (rsp_port.ready)
   );

   // Drive the response channel.
   assign rsp_port.valid        = rsp_valid;
   assign rsp_port.action       = rsp_result.action;
   assign rsp_port.status       = rsp_result.status;
   assign rsp_port.error_detail = rsp_result.error_detail;
   assign rsp_port.last         = rsp_result.last;

endmodule

`default_nettype wire

// File: sv/fcs_checker.sv
// ----------------------------------------------------------------------------
// Flash command sequencer port checker
// Concurrent checks on the sequencer's response channel over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flash_command_sequencer_unit_macros.svh"

module fcs_checker import fcs_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ACTION_W-1:0] rsp_action,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [CODE_W-1:0]   rsp_error_detail,
   input wire logic                rsp_last
);

   logic [ACTION_W+STATUS_W+CODE_W:0] rsp_payload;
   logic                              rsp_issue;
   logic                              rsp_clean;
   logic                              rsp_coded;

   // Short names for the conditions that the checks look at.
   assign rsp_payload = {rsp_action, rsp_status, rsp_error_detail, rsp_last};
   assign rsp_issue   = rsp_valid && (rsp_action != ACT_COMPLETE);
   assign rsp_clean   = (rsp_status == ST_OK) && (rsp_error_detail == '0);
   assign rsp_coded   = rsp_valid && (rsp_error_detail != '0);

   // A stalled result item holds its value.
   `FCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // No result item is offered in the cycle after reset.
   `FCS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // A completion always ends the results of its item.
   `FCS_ASSERT(a_complete_last, clock, reset, rsp_valid && rsp_action == ACT_COMPLETE |-> rsp_last)

   // Only a completion carries a status or an error code.
   `FCS_ASSERT(a_issue_clean, clock, reset, rsp_issue |-> rsp_clean)

   // An error code comes only with a transfer error.
   `FCS_ASSERT(a_detail_xfer, clock, reset, rsp_coded |-> rsp_status == ST_XFER_ERR)

endmodule

bind flash_command_sequencer_unit fcs_checker u_fcs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_action       (rsp_port.action),
   .rsp_status       (rsp_port.status),
   .rsp_error_detail (rsp_port.error_detail),
   .rsp_last         (rsp_port.last)
);

`default_nettype wire
